### hdl/srp_pkg.sv
package srp_pkg;

  // Packed pattern and replacement registers are fixed at eight bytes.
  localparam int CFG_BYTES     = 8;
  localparam int CFG_DATA_W    = 8 * CFG_BYTES;
  localparam int CFG_LEN_W     = 4;
  localparam int CFG_IDX_W     = 2;

  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES = 2'd0,
    CFG_PATTERN_LEN   = 2'd1,
    CFG_REPL_BYTES    = 2'd2,
    CFG_REPL_LEN      = 2'd3
  } cfg_idx_e;

  // Control that rides along with one burst of results.
  typedef struct packed {
    logic marker;    // burst is a single end marker with no byte
    logic str_last;  // burst closes the string
  } srp_burst_t;

endpackage

### hdl/srp_in_if.sv
interface srp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_last;

  modport source (output valid, output in_byte, output string_last, input ready);
  modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface

### hdl/srp_out_if.sv
interface srp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output string_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input string_end, output ready);
endinterface

### hdl/srp_window.sv
module srp_window import srp_pkg::*; #(
  parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT,
  parameter int EMIT_N          = DEF_MAX_PATTERN,
  parameter int PW              = $clog2(DEF_MAX_PATTERN + 1),
  parameter int RW              = $clog2(DEF_MAX_REPLACEMENT + 2),
  parameter int NW              = $clog2(DEF_MAX_PATTERN + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic                       clear_i,
  input  logic [7:0]                 in_byte_i,
  input  logic                       last_i,
  input  logic [PW-1:0]              plen_i,
  input  logic [RW-1:0]              rlen_i,
  input  logic [CFG_DATA_W-1:0]      pattern_i,
  input  logic [CFG_DATA_W-1:0]      repl_i,
  output logic [EMIT_N-1:0][7:0]     emit_bytes_o,
  output logic [NW-1:0]              emit_cnt_o,
  output srp_burst_t                 emit_ctrl_o
);

  localparam int PAT_EXT_W = 8 * (MAX_PATTERN + CFG_BYTES);
  localparam int REP_EXT_W = 8 * (MAX_REPLACEMENT + CFG_BYTES);

  logic [MAX_PATTERN-1:0][7:0] win_q, win_d, win_app;
  logic [PW-1:0]               cnt_q, cnt_d, cnt_eff, cnt_app;
  logic [PAT_EXT_W-1:0]        pat_ext;
  logic [REP_EXT_W-1:0]        rep_ext;
  logic                        full, match;
  logic [NW-1:0]               n_emit;

  assign pat_ext = PAT_EXT_W'(pattern_i);
  assign rep_ext = REP_EXT_W'(repl_i);

  always_comb begin
    cnt_eff = (cnt_q >= plen_i) ? '0 : cnt_q;
    cnt_app = cnt_eff + PW'(1);
    full    = (cnt_app == plen_i);

    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_app[i] = (PW'(i) == cnt_eff) ? in_byte_i : win_q[i];
    end

    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((PW'(i) < plen_i) && (win_app[i] != pat_ext[8*i +: 8])) begin
        match = 1'b0;
      end
    end

    // Matched window sends the replacement; otherwise the window itself.
    emit_bytes_o = '0;
    if (full && match) begin
      for (int i = 0; i < MAX_REPLACEMENT; i++) begin
        emit_bytes_o[i] = rep_ext[8*i +: 8];
      end
    end else begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        emit_bytes_o[i] = win_app[i];
      end
    end

    if (full && match) begin
      n_emit = NW'(rlen_i);
    end else if (full) begin
      n_emit = last_i ? NW'(plen_i) : NW'(1);
    end else begin
      n_emit = last_i ? NW'(cnt_app) : '0;
    end

    emit_ctrl_o.marker   = (n_emit == '0);
    emit_ctrl_o.str_last = last_i;
    emit_cnt_o           = ((n_emit == '0) && last_i) ? NW'(1) : n_emit;
  end

  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    if (clear_i) begin
      cnt_d = '0;
    end else if (fire_i) begin
      win_d = win_app;
      if (full && match) begin
        cnt_d = '0;
      end else if (full) begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          win_d[i] = win_app[i+1];
        end
        cnt_d = plen_i - PW'(1);
      end else begin
        cnt_d = cnt_app;
      end
      if (last_i) begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

### hdl/srp_emitter.sv
module srp_emitter import srp_pkg::*; #(
  parameter int EMIT_N = DEF_MAX_PATTERN,
  parameter int NW     = $clog2(DEF_MAX_PATTERN + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [EMIT_N-1:0][7:0] ld_bytes_i,
  input  logic [NW-1:0]          ld_cnt_i,
  input  srp_burst_t             ld_ctrl_i,
  input  logic                   out_ready_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output logic [7:0]             out_byte_o,
  output logic                   byte_valid_o,
  output logic                   run_last_o,
  output logic                   string_end_o
);

  logic [EMIT_N-1:0][7:0] bytes_q, bytes_d;
  logic [NW-1:0]          rem_q, rem_d;
  srp_burst_t             ctrl_q, ctrl_d;
  logic                   out_fire;

  assign out_valid_o  = (rem_q != '0);
  assign out_fire     = out_valid_o && out_ready_i;
  assign run_last_o   = (rem_q == NW'(1));
  assign string_end_o = run_last_o && ctrl_q.str_last;
  assign byte_valid_o = !ctrl_q.marker;
  assign out_byte_o   = ctrl_q.marker ? 8'h00 : bytes_q[0];

  // Take a new burst when none is pending or the current one's final transfer is being taken.
  assign in_ready_o = (rem_q == '0) || (run_last_o && out_ready_i);

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    ctrl_d  = ctrl_q;
    if (load_i) begin
      bytes_d = ld_bytes_i;
      rem_d   = ld_cnt_i;
      ctrl_d  = ld_ctrl_i;
    end else if (out_fire) begin
      for (int i = 0; i < EMIT_N - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      rem_d = rem_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      ctrl_q <= '0;
    end else begin
      rem_q  <= rem_d;
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

### hdl/stream_pattern_replace_top.sv
// Streaming find-and-replace.
// in_i carries one text byte per transfer plus string_last on the final byte
// of a string. Results leave on out_o one byte per transfer with
// byte_valid, run_last (last result of the input byte that caused it) and
// string_end (final result of the string). A string that ends with nothing
// to send yields one end marker: byte_valid low, run_last and string_end high.
// The pattern (1..MAX_PATTERN bytes) is matched in a window of at most
// pattern-length bytes; every leftmost, non-overlapping match is replaced by
// the replacement (0..MAX_REPLACEMENT bytes). Leftover window bytes flush
// unchanged at string end. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while the block is
// idle, which the block does not enforce. Writing the pattern length empties
// the window. The first result of a byte is on out_o the cycle after its
// transfer. in_i takes one byte per cycle while out_o is ready and each byte
// yields at most one result; a byte with more results holds in_i until the
// last of them is taken, as the result register drains one result per cycle
// while out_o is ready. When out_o stalls, results hold and in_i takes a new
// byte only on the last pending transfer. Reset empties the window and result
// register, restoring the defaults (pattern length one, empty replacement).
module stream_pattern_replace_top import srp_pkg::*; #(
  parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srp_in_if.sink                in_i,
  srp_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // One burst is as long as the longer of a full window or a replacement.
  localparam int EMIT_N = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int PW     = $clog2(MAX_PATTERN + 1);
  localparam int RW     = $clog2(MAX_REPLACEMENT + 2);
  localparam int NW     = $clog2(EMIT_N + 1);

  logic [CFG_DATA_W-1:0] pat_q, rep_q;
  logic [CFG_LEN_W-1:0]  plen_q, rlen_q;
  logic [PW-1:0]         plen_eff;
  logic [RW-1:0]         rlen_eff;
  logic                  win_clear;
  logic                  in_fire;

  logic [EMIT_N-1:0][7:0] emit_bytes;
  logic [NW-1:0]          emit_cnt;
  srp_burst_t             emit_ctrl;

  // Configuration registers; out-of-range codes cannot be addressed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= CFG_LEN_W'(1);
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_BYTES: pat_q  <= cfg_data_i;
        CFG_PATTERN_LEN:   plen_q <= cfg_data_i[CFG_LEN_W-1:0];
        CFG_REPL_BYTES:    rep_q  <= cfg_data_i;
        CFG_REPL_LEN:      rlen_q <= cfg_data_i[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A new pattern length drops whatever the window holds.
  assign win_clear = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_PATTERN_LEN);

  // Clamp lengths: zero pattern acts as one, both saturate at their maximum.
  always_comb begin
    if (plen_q == '0) begin
      plen_eff = PW'(1);
    end else if (32'(plen_q) > MAX_PATTERN) begin
      plen_eff = PW'(MAX_PATTERN);
    end else begin
      plen_eff = PW'(plen_q);
    end
    if (32'(rlen_q) > MAX_REPLACEMENT) begin
      rlen_eff = RW'(MAX_REPLACEMENT);
    end else begin
      rlen_eff = RW'(rlen_q);
    end
  end

  assign in_fire = in_i.valid && in_i.ready;

  srp_window #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .EMIT_N          (EMIT_N),
    .PW              (PW),
    .RW              (RW),
    .NW              (NW)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .clear_i      (win_clear),
    .in_byte_i    (in_i.in_byte),
    .last_i       (in_i.string_last),
    .plen_i       (plen_eff),
    .rlen_i       (rlen_eff),
    .pattern_i    (pat_q),
    .repl_i       (rep_q),
    .emit_bytes_o (emit_bytes),
    .emit_cnt_o   (emit_cnt),
    .emit_ctrl_o  (emit_ctrl)
  );

  srp_emitter #(
    .EMIT_N (EMIT_N),
    .NW     (NW)
  ) u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_fire),
    .ld_bytes_i   (emit_bytes),
    .ld_cnt_i     (emit_cnt),
    .ld_ctrl_i    (emit_ctrl),
    .out_ready_i  (out_o.ready),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_byte_o   (out_o.out_byte),
    .byte_valid_o (out_o.byte_valid),
    .run_last_o   (out_o.run_last),
    .string_end_o (out_o.string_end)
  );

  // An end marker only ever closes a string.
  a_marker_ends_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.byte_valid) |-> (out_o.run_last && out_o.string_end))
    else $error("end marker without string end");

  // A new byte is taken only while the pending burst finishes.
  a_no_burst_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_o.valid) |-> (out_o.ready && out_o.run_last))
    else $error("input taken over pending results");

  // The end of a string always produces at least one result.
  a_string_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.string_last) |-> (emit_cnt != '0))
    else $error("string end produced no result");

  // string_end is only ever on the last result of a byte.
  a_end_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.string_end) |-> out_o.run_last)
    else $error("string end before last result of the byte");

endmodule

### verif/srp_replace_checker.sv
`timescale 1ns / 1ps

module srp_replace_checker import srp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srp_in_if                     in_mon,
  srp_out_if                    out_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  localparam int MAX_PAT = DEF_MAX_PATTERN;
  localparam int MAX_REP = DEF_MAX_REPLACEMENT;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } srp_result_t;

  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [CFG_LEN_W-1:0]  pat_len;
  logic [CFG_DATA_W-1:0] rep_bytes;
  logic [CFG_LEN_W-1:0]  rep_len;
  logic [7:0]            window [MAX_PAT];
  int unsigned           window_fill;
  srp_result_t           expected_q [$];

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_count_o < PRINT_CAP) begin
      $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    end
    fail_count_o++;
  endtask

  // Append one byte to the match window and queue the results it produces.
  function automatic void predict_replace(input logic [7:0] in_byte, input logic last);
    logic [7:0]  emit_q [$];
    int unsigned plen;
    int unsigned rlen;
    logic        hit;
    srp_result_t res;
    plen = (pat_len == 0) ? 1 : ((pat_len > MAX_PAT) ? MAX_PAT : pat_len);
    rlen = (rep_len > MAX_REP) ? MAX_REP : rep_len;
    if (window_fill >= plen) window_fill = 0;
    window[window_fill] = in_byte;
    window_fill++;
    if (window_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < rlen; i++) emit_q.push_back(rep_bytes[8*i +: 8]);
        window_fill = 0;
      end else begin
        emit_q.push_back(window[0]);
        for (int i = 1; i < plen; i++) window[i-1] = window[i];
        window_fill--;
      end
    end
    if (last) begin
      for (int i = 0; i < window_fill; i++) emit_q.push_back(window[i]);
      window_fill = 0;
    end
    if (emit_q.size() == 0 && last) begin
      res = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, string_end: 1'b1};
      expected_q.push_back(res);
    end
    for (int i = 0; i < emit_q.size(); i++) begin
      res.out_byte   = emit_q[i];
      res.byte_valid = 1'b1;
      res.run_last   = (i == emit_q.size() - 1);
      res.string_end = (i == emit_q.size() - 1) && last;
      expected_q.push_back(res);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    srp_result_t want;
    if (!rst_ni) begin
      pat_bytes    = '0;
      pat_len      = CFG_LEN_W'(1);
      rep_bytes    = '0;
      rep_len      = '0;
      window_fill  = 0;
      for (int i = 0; i < MAX_PAT; i++) window[i] = 8'h00;
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, out_byte", out_mon.out_byte, 8'h00);
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (out_mon.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_mon.out_byte, want.out_byte);
          if (out_mon.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 8'(out_mon.byte_valid), 8'(want.byte_valid));
          if (out_mon.run_last !== want.run_last)
            report_mismatch("run_last", 8'(out_mon.run_last), 8'(want.run_last));
          if (out_mon.string_end !== want.string_end)
            report_mismatch("string_end", 8'(out_mon.string_end), 8'(want.string_end));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN_BYTES: pat_bytes = cfg_data_i;
          CFG_PATTERN_LEN: begin
            pat_len     = cfg_data_i[CFG_LEN_W-1:0];
            window_fill = 0;
          end
          CFG_REPL_BYTES: rep_bytes = cfg_data_i;
          CFG_REPL_LEN: rep_len = cfg_data_i[CFG_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_replace(in_mon.in_byte, in_mon.string_last);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### verif/tb_stream_pattern_replace_top.sv
`timescale 1ns / 1ps

module tb_stream_pattern_replace_top import srp_pkg::*;;

  // Worst case is far below this: every byte expanding eight times with the
  // receiver stalling most cycles, plus the long hold-off stretches.
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned SETTLE_TIME  = 4;
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned PHASE_ITEMS  = 22;
  localparam int unsigned HOLD_STRETCH = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  srp_in_if  in_ch ();
  srp_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Traffic shaping shared between the byte sender and the result sink.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_cycles    = 0;

  // Current pattern, kept so that generated text hits it often.
  logic [CFG_DATA_W-1:0] gen_pattern = '0;
  int unsigned           gen_plen    = 1;

  int unsigned items_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned settings     = 0;
  int unsigned cycle_count  = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  stream_pattern_replace_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  srp_replace_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Result sink: honor a requested hold-off first, else stall at random.
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Write one register; enter and leave on a falling edge.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
    if (idx == CFG_PATTERN_BYTES) gen_pattern = data;
    if (idx == CFG_PATTERN_LEN) begin
      gen_plen = (data[CFG_LEN_W-1:0] == 0) ? 1 :
                 ((data[CFG_LEN_W-1:0] > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN :
                  data[CFG_LEN_W-1:0]);
    end
  endtask

  // Offer one byte, idling first at the current rate; hold valid high after
  // the transfer so back-to-back bytes need no drop in between.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.in_byte     = b;
    in_ch.string_last = last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (last) strings_sent++;
  endtask

  // Build text from whole patterns, pattern prefixes, pattern bytes and noise.
  task automatic send_text(input int unsigned len, input bit finish);
    logic [7:0]  text [$];
    int unsigned pick;
    int unsigned cut;
    while (text.size() < len) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        for (int i = 0; i < gen_plen; i++) text.push_back(gen_pattern[8*i +: 8]);
      end else if (pick < 6) begin
        cut = $urandom_range(gen_plen - 1);
        for (int i = 0; i < cut; i++) text.push_back(gen_pattern[8*i +: 8]);
      end else if (pick < 8) begin
        text.push_back(gen_pattern[8*$urandom_range(gen_plen - 1) +: 8]);
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    while (text.size() > len) void'(text.pop_back());
    foreach (text[i]) send_byte(text[i], finish && (i == text.size() - 1));
  endtask

  // Drop valid, drain every expected result, then wait out SETTLE_TIME for bytes that produced nothing.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_TIME) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    logic [CFG_LEN_W-1:0] plen_val;
    logic [CFG_LEN_W-1:0] rlen_val;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = 8'h00;
    in_ch.string_last = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_PATTERN_BYTES;
    cfg_data          = '0;

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: pattern "abc" replaced by "XY".
    write_reg(CFG_PATTERN_BYTES, 64'h636261);
    write_reg(CFG_PATTERN_LEN, 64'd3);
    write_reg(CFG_REPL_BYTES, 64'h5958);
    write_reg(CFG_REPL_LEN, 64'd2);
    settings++;
    // Match on the closing byte of a string.
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b1);
    // String shorter than the pattern flushes unchanged, byte extremes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    // Single-byte string.
    send_byte("x", 1'b1);
    settle();

    // Held bytes are dropped when the pattern length is rewritten.
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    settle();
    write_reg(CFG_PATTERN_LEN, 64'd3);
    send_byte("c", 1'b1);
    settle();

    // Empty replacement: a final match leaves only the end marker.
    write_reg(CFG_REPL_LEN, 64'd0);
    settings++;
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b1);
    send_byte("a", 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b0);
    send_byte("d", 1'b1);
    settle();

    // One-byte pattern, eight-byte replacement: the widest burst.
    write_reg(CFG_PATTERN_BYTES, 64'h61);
    write_reg(CFG_PATTERN_LEN, 64'd1);
    write_reg(CFG_REPL_BYTES, 64'h3736353433323130);
    write_reg(CFG_REPL_LEN, 64'd8);
    settings++;
    send_byte("a", 1'b1);
    send_byte("q", 1'b0);
    send_byte("a", 1'b1);
    settle();

    // Random phases. Traffic rotates through no idling, sender idle,
    // receiver stalling and both; the settings start at the extremes.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase

      case (p)
        0: plen_val = 4'd1;
        1: plen_val = 4'd8;
        2: plen_val = 4'd0;
        3: plen_val = 4'd15;
        default: plen_val = 4'($urandom_range(15));
      endcase
      case (p)
        0: rlen_val = 4'd8;
        1: rlen_val = 4'd0;
        3: rlen_val = 4'd15;
        default: rlen_val = 4'($urandom_range(15));
      endcase

      case (p)
        0: write_reg(CFG_PATTERN_BYTES, '0);
        3: write_reg(CFG_PATTERN_BYTES, '1);
        default: write_reg(CFG_PATTERN_BYTES, {$urandom, $urandom});
      endcase
      case (p)
        0: write_reg(CFG_REPL_BYTES, '1);
        1: write_reg(CFG_REPL_BYTES, '0);
        default: write_reg(CFG_REPL_BYTES, {$urandom, $urandom});
      endcase
      write_reg(CFG_REPL_LEN, CFG_DATA_W'(rlen_val));
      // Two phases keep the pattern length, so the window left open by the
      // phase before carries over into the new pattern and replacement.
      if (p != 5 && p != 7) write_reg(CFG_PATTERN_LEN, CFG_DATA_W'(plen_val));
      settings++;

      // Block the result side for a long stretch while bytes keep coming.
      if (p == 0 || p == 4) hold_cycles = HOLD_STRETCH;

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_text($urandom_range(1, 2 * gen_plen + 6), 1'b1);
      end
      // Leave some phases in the middle of a string.
      if (p == 1 || p == 4 || p == 6) send_text($urandom_range(1, 3), 1'b0);
      settle();
    end

    $display("Covered %0d bytes in %0d strings over %0d register settings,", items_sent,
             strings_sent, settings);
    $display("with %0d results checked under mixed idling and a long receiver hold-off.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/srp_pkg.sv
hdl/srp_in_if.sv
hdl/srp_out_if.sv
hdl/srp_window.sv
hdl/srp_emitter.sv
hdl/stream_pattern_replace_top.sv
verif/srp_replace_checker.sv
verif/tb_stream_pattern_replace_top.sv
